FILE: rtl/core/cpf_pkg.sv
// Shared types and constants for the command packet framer.
package cpf_pkg;

   // Command numbers that select the packet class.
   localparam logic [7:0] CMD_SET_FIRST    = 8'd0;
   localparam logic [7:0] CMD_NULL         = 8'd1;
   localparam logic [7:0] CMD_SET_WIDE_A   = 8'd2;
   localparam logic [7:0] CMD_SET_ONE_A    = 8'd3;
   localparam logic [7:0] CMD_SET_WIDE_B   = 8'd4;
   localparam logic [7:0] CMD_SET_ONE_FIRST = 8'd5;
   localparam logic [7:0] CMD_SET_ONE_LAST = 8'd8;
   localparam logic [7:0] CMD_SET_WIDE_C   = 8'd9;
   localparam logic [7:0] CMD_SET_LAST     = 8'd10;
   localparam logic [7:0] CMD_READ_FIRST   = 8'd11;
   localparam logic [7:0] CMD_READ_LAST    = 8'd20;
   localparam logic [7:0] CMD_STATUS       = 8'd21;
   localparam logic [7:0] CMD_FREE_RUN     = 8'd22;
   localparam logic [7:0] CMD_PRESET_RUN   = 8'd23;
   localparam logic [7:0] CMD_FINE_RUN     = 8'd24;
   localparam logic [7:0] CMD_STATUS_IDX4  = 8'd25;
   localparam logic [7:0] CMD_CLASS5       = 8'd26;
   localparam logic [7:0] CMD_CLASS6       = 8'd27;

   // Subcommand bias for the set and read classes.
   localparam logic [7:0] SET_SUB_BIAS     = 8'd2;
   localparam logic [7:0] READ_SUB_BIAS    = 8'd11;

   // Byte positions inside a packet.
   localparam logic [3:0] POS_ADDR         = 4'd0;
   localparam logic [3:0] POS_LEN          = 4'd1;
   localparam logic [3:0] POS_HDR_A        = 4'd4;
   localparam logic [3:0] POS_HDR_B        = 4'd6;
   localparam logic [3:0] POS_SUB          = 4'd8;
   localparam logic [3:0] POS_ARG0         = 4'd9;
   localparam logic [3:0] POS_ARG1         = 4'd10;
   localparam logic [3:0] POS_ARG2         = 4'd11;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic advance;
      logic emit_bad;
   } cpf_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic cmd_bad;
      logic at_last;
   } cpf_sts_type;

endpackage

FILE: rtl/core/cpf_ctrl.sv
// Controller state machine for the command packet framer.
module cpf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  cpf_pkg::cpf_sts_type sts,
   output cpf_pkg::cpf_cmd_type cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SEND = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.advance  = 1'b0;
      cmd.emit_bad = 1'b0;
      rsp_valid    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
            if (start) begin
               state_in = sts.cmd_bad ? ST_BAD : ST_SEND;
            end
         end
         ST_SEND: begin
            cmd.advance = 1'b1;
            rsp_valid   = 1'b1;
            if (sts.at_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_BAD: begin
            cmd.emit_bad = 1'b1;
            rsp_valid    = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: rtl/core/cpf_dpath.sv
// Datapath for the command packet framer: class decode, packet fields, byte select, checksum.
module cpf_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  cpf_pkg::cpf_cmd_type cmd,
   output cpf_pkg::cpf_sts_type sts,
   input  logic [7:0]           req_cmd,
   input  logic [7:0]           req_device_addr,
   input  logic [7:0]           req_arg0,
   input  logic [7:0]           req_arg1,
   input  logic [7:0]           req_arg2,
   output logic [7:0]           rsp_out_byte,
   output logic [3:0]           rsp_packet_length,
   output logic                 rsp_last,
   output logic                 rsp_bad_command
);

   // Decoded class of the incoming command.
   logic [3:0] dec_len;
   logic [2:0] dec_hdr_a;
   logic [2:0] dec_hdr_b;
   logic [7:0] dec_sub;
   logic       dec_bad;

   always_comb begin
      dec_len   = 4'd8;
      dec_hdr_a = 3'd0;
      dec_hdr_b = 3'd0;
      dec_sub   = 8'd0;
      dec_bad   = 1'b0;
      unique case (req_cmd) inside
         cpf_pkg::CMD_NULL: begin
            dec_len = 4'd8;
         end
         cpf_pkg::CMD_SET_WIDE_A, cpf_pkg::CMD_SET_WIDE_B,
         cpf_pkg::CMD_SET_WIDE_C, cpf_pkg::CMD_SET_LAST: begin
            dec_len   = 4'd11;
            dec_hdr_a = 3'd1;
            dec_hdr_b = 3'd3;
            dec_sub   = req_cmd - cpf_pkg::SET_SUB_BIAS;
         end
         cpf_pkg::CMD_SET_FIRST, cpf_pkg::CMD_SET_ONE_A,
         [cpf_pkg::CMD_SET_ONE_FIRST:cpf_pkg::CMD_SET_ONE_LAST]: begin
            // Remaining set commands carry one argument; command zero wraps.
            dec_len   = 4'd10;
            dec_hdr_a = 3'd1;
            dec_hdr_b = 3'd2;
            dec_sub   = req_cmd - cpf_pkg::SET_SUB_BIAS;
         end
         [cpf_pkg::CMD_READ_FIRST:cpf_pkg::CMD_READ_LAST]: begin
            dec_len   = 4'd9;
            dec_hdr_a = 3'd2;
            dec_hdr_b = 3'd1;
            dec_sub   = req_cmd - cpf_pkg::READ_SUB_BIAS;
         end
         cpf_pkg::CMD_STATUS: begin
            dec_len   = 4'd9;
            dec_hdr_a = 3'd3;
            dec_hdr_b = 3'd1;
         end
         cpf_pkg::CMD_FREE_RUN: begin
            dec_len   = 4'd10;
            dec_hdr_a = 3'd3;
            dec_hdr_b = 3'd2;
            dec_sub   = 8'd1;
         end
         cpf_pkg::CMD_PRESET_RUN: begin
            dec_len   = 4'd11;
            dec_hdr_a = 3'd3;
            dec_hdr_b = 3'd3;
            dec_sub   = 8'd2;
         end
         cpf_pkg::CMD_FINE_RUN: begin
            dec_len   = 4'd12;
            dec_hdr_a = 3'd3;
            dec_hdr_b = 3'd4;
            dec_sub   = 8'd3;
         end
         cpf_pkg::CMD_STATUS_IDX4: begin
            dec_len   = 4'd9;
            dec_hdr_a = 3'd3;
            dec_hdr_b = 3'd1;
            dec_sub   = 8'd4;
         end
         cpf_pkg::CMD_CLASS5: begin
            dec_hdr_a = 3'd5;
         end
         cpf_pkg::CMD_CLASS6: begin
            dec_hdr_a = 3'd6;
         end
         default: begin
            dec_bad = 1'b1;
         end
      endcase
   end

   // Packet fields held for the duration of one packet.
   logic [7:0] addr_ff;
   logic [3:0] len_ff;
   logic [2:0] hdr_a_ff;
   logic [2:0] hdr_b_ff;
   logic [7:0] sub_ff;
   logic [7:0] arg0_ff;
   logic [7:0] arg1_ff;
   logic [7:0] arg2_ff;
   logic [3:0] idx_ff;
   logic [3:0] idx_in;
   logic [7:0] sum_ff;
   logic [7:0] sum_in;
   logic [7:0] cur_byte;
   logic       at_last;

   assign at_last = (idx_ff == len_ff);

   always_comb begin
      if (at_last) begin
         cur_byte = 8'd0 - sum_ff;
      end else begin
         case (idx_ff)
            cpf_pkg::POS_ADDR:  cur_byte = addr_ff;
            cpf_pkg::POS_LEN:   cur_byte = {4'd0, len_ff};
            cpf_pkg::POS_HDR_A: cur_byte = {5'd0, hdr_a_ff};
            cpf_pkg::POS_HDR_B: cur_byte = {5'd0, hdr_b_ff};
            cpf_pkg::POS_SUB:   cur_byte = sub_ff;
            cpf_pkg::POS_ARG0:  cur_byte = arg0_ff;
            cpf_pkg::POS_ARG1:  cur_byte = arg1_ff;
            cpf_pkg::POS_ARG2:  cur_byte = arg2_ff;
            default:            cur_byte = 8'd0;
         endcase
      end
   end

   always_comb begin
      idx_in = idx_ff;
      sum_in = sum_ff;
      if (cmd.load) begin
         idx_in = 4'd0;
         sum_in = 8'd0;
      end else if (cmd.advance) begin
         idx_in = idx_ff + 4'd1;
         // The address byte stays out of the checksum.
         if (idx_ff != cpf_pkg::POS_ADDR) begin
            sum_in = sum_ff + cur_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 4'd0;
         sum_ff <= 8'd0;
      end else begin
         idx_ff <= idx_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff  <= req_device_addr;
         len_ff   <= dec_len;
         hdr_a_ff <= dec_hdr_a;
         hdr_b_ff <= dec_hdr_b;
         sub_ff   <= dec_sub;
         arg0_ff  <= req_arg0;
         arg1_ff  <= req_arg1;
         arg2_ff  <= req_arg2;
      end
   end

   assign sts.cmd_bad = dec_bad;
   assign sts.at_last = at_last;

   assign rsp_out_byte      = cmd.emit_bad ? 8'd0 : cur_byte;
   assign rsp_packet_length = cmd.emit_bad ? 4'd0 : (len_ff + 4'd1);
   assign rsp_last          = cmd.emit_bad | at_last;
   assign rsp_bad_command   = cmd.emit_bad;

endmodule

FILE: rtl/core/command_packet_framer.sv
// Top level of the command packet framer.
//
// A command word is presented on req_cmd, req_device_addr and req_arg0..2 and is
// taken at a rising clock edge where start is high and busy is low. The block
// then sends the framed packet one byte per cycle on the rsp_ ports, each byte
// marked by rsp_valid for exactly one cycle. The packet holds the address, a
// little-endian length, the class header, a subcommand, the arguments and a
// closing checksum byte; rsp_last marks the checksum byte.
// The first byte appears in the cycle that follows the accepting edge. A packet
// of N bytes (9 to 13) keeps busy high until its last byte is sent, and a
// new start is taken only once busy is low again; the byte index in the
// datapath walks the packet one byte a cycle up to the stored length.
// A command number above the valid range gives a single word with
// rsp_bad_command and rsp_last high, byte and length zero.
// Reset returns the controller to idle and drops busy and rsp_valid; a packet
// in flight is abandoned. The receiver cannot stall: every rsp_valid cycle is a
// delivered word.
module command_packet_framer (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_cmd,
   input  logic [7:0] req_device_addr,
   input  logic [7:0] req_arg0,
   input  logic [7:0] req_arg1,
   input  logic [7:0] req_arg2,
   output logic       rsp_valid,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_packet_length,
   output logic       rsp_last,
   output logic       rsp_bad_command
);

   cpf_pkg::cpf_cmd_type dp_cmd;
   cpf_pkg::cpf_sts_type dp_sts;

   // The controller sequences load, byte send and the bad-command word.
   cpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (dp_sts),
      .cmd       (dp_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // The datapath decodes the class, holds the fields and builds each byte.
   cpf_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .sts               (dp_sts),
      .req_cmd           (req_cmd),
      .req_device_addr   (req_device_addr),
      .req_arg0          (req_arg0),
      .req_arg1          (req_arg1),
      .req_arg2          (req_arg2),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_packet_length (rsp_packet_length),
      .rsp_last          (rsp_last),
      .rsp_bad_command   (rsp_bad_command)
   );

endmodule

FILE: rtl/core/cpf_checker.sv
// Port-level checker for the command packet framer, bound to the top level.
module cpf_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [7:0] req_cmd,
   input logic [7:0] req_device_addr,
   input logic [7:0] req_arg0,
   input logic [7:0] req_arg1,
   input logic [7:0] req_arg2,
   input logic       rsp_valid,
   input logic [7:0] rsp_out_byte,
   input logic [3:0] rsp_packet_length,
   input logic       rsp_last,
   input logic       rsp_bad_command
);

   // An accepted command always produces at least one word.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && rsp_valid)
      else $error("accepted command did not start output");

   // Words appear only while a command is in progress.
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("word presented while idle");

   // Packet bytes go out back to back until the last one.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid && !rsp_bad_command)
      else $error("gap or bad flag inside a packet");

   // The last word frees the block.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !busy)
      else $error("block still busy after last word");

   // A bad-command word is a lone word with zero length.
   a_bad_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_command |-> rsp_last && (rsp_packet_length == 4'd0))
      else $error("malformed bad-command word");

endmodule

bind command_packet_framer cpf_checker u_cpf_checker (.*);
